[hw/rtl/bcm_pkg.sv]
package bcm_pkg;

  localparam int DefMaxWidth  = 1024;
  localparam int DefMaxHeight = 1024;
  localparam int ResetSize    = 1024;

  localparam int CfgDataBits = 11;
  localparam int CfgIdxBits  = 2;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // number of window terms: above, left, center, right, current pixel
  localparam int NumTerms = 5;

  typedef enum logic [CfgIdxBits-1:0] {
    RegImageWidth  = 2'd0,
    RegImageHeight = 2'd1,
    RegMorphOp     = 2'd2
  } bcm_reg_e;

  typedef enum logic {
    OpErode  = 1'b0,
    OpDilate = 1'b1
  } bcm_op_e;

  typedef struct packed {
    logic pixel_in;
    logic flush;
  } bcm_in_t;

  typedef struct packed {
    logic pixel_out;
    logic frame_last;
  } bcm_out_t;

  // one line buffer entry: the row two above and the row just above
  typedef struct packed {
    logic above;
    logic center;
  } bcm_line_t;

  typedef struct packed {
    logic [NumTerms-1:0] terms;
    logic [NumTerms-1:0] uses;
    bcm_op_e             op;
    logic                last;
  } bcm_entry_t;

  typedef struct packed {
    logic [QCntW-1:0] count;
    logic             valid;
  } bcm_qstat_t;

endpackage

[hw/rtl/bcm_front.sv]
module bcm_front #(
  parameter int MAX_WIDTH  = bcm_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = bcm_pkg::DefMaxHeight
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bcm_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [bcm_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  bcm_pkg::bcm_in_t                in_item_i,
  input  bcm_pkg::bcm_qstat_t             qstat_i,
  output logic                            push_o,
  output bcm_pkg::bcm_entry_t             push_entry_o
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int WReset = (MAX_WIDTH < bcm_pkg::ResetSize) ? MAX_WIDTH : bcm_pkg::ResetSize;
  localparam int HReset = (MAX_HEIGHT < bcm_pkg::ResetSize) ? MAX_HEIGHT : bcm_pkg::ResetSize;

  logic [WW-1:0]    width_q, width_d;
  logic [RW-1:0]    height_q, height_d;
  bcm_pkg::bcm_op_e op_q, op_d;
  logic             restart;

  logic [AW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          left_q;

  logic [WW-1:0] col_inc;
  logic [RW:0]   row_inc;
  logic          last_col, flush_phase, drop, accept, take, has_result;
  logic [AW-1:0] rd_addr;

  bcm_pkg::bcm_line_t line_mem [MAX_WIDTH];
  bcm_pkg::bcm_line_t rd_q, wr_data;

  logic             s1_valid_q;
  logic             s1_above_q, s1_left_q, s1_cen_q, s1_px_q;
  logic             s1_above_use_q, s1_left_use_q, s1_right_use_q, s1_px_use_q;
  logic             s1_last_q;
  bcm_pkg::bcm_op_e s1_op_q;

  // configuration, sizes clamped on write
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    op_d     = op_q;
    restart  = 1'b0;
    if (cfg_we_i) begin
      unique case (bcm_pkg::bcm_reg_e'(cfg_idx_i))
        bcm_pkg::RegImageWidth: begin
          restart = 1'b1;
          if (cfg_data_i == '0) width_d = WW'(1);
          else if (int'(cfg_data_i) > MAX_WIDTH) width_d = WW'(MAX_WIDTH);
          else width_d = WW'(cfg_data_i);
        end
        bcm_pkg::RegImageHeight: begin
          restart = 1'b1;
          if (cfg_data_i == '0) height_d = RW'(1);
          else if (int'(cfg_data_i) > MAX_HEIGHT) height_d = RW'(MAX_HEIGHT);
          else height_d = RW'(cfg_data_i);
        end
        bcm_pkg::RegMorphOp: begin
          restart = 1'b1;
          op_d    = bcm_pkg::bcm_op_e'(cfg_data_i[0]);
        end
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(WReset);
      height_q <= RW'(HReset);
      op_q     <= bcm_pkg::OpErode;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      op_q     <= op_d;
    end
  end

  // room for the item in flight plus everything queued
  assign in_ready_o = (qstat_i.count + bcm_pkg::QCntW'(s1_valid_q))
                      < bcm_pkg::QCntW'(bcm_pkg::QDepth);
  assign accept = in_valid_i && in_ready_o;

  assign col_inc     = WW'(col_q) + WW'(1);
  assign row_inc     = {1'b0, row_q} + (RW+1)'(1);
  assign last_col    = (col_inc == width_q);
  assign flush_phase = (row_q == height_q);
  assign drop        = !flush_phase && in_item_i.flush;
  assign take        = accept && !drop;
  assign has_result  = (row_q != '0);
  // look one column ahead; the last column wraps to the next row's start
  assign rd_addr     = last_col ? '0 : col_inc[AW-1:0];
  assign wr_data     = '{above: rd_q.center, center: in_item_i.pixel_in};

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (take) begin
      if (last_col) begin
        col_d = '0;
        row_d = (row_inc > {1'b0, height_q}) ? '0 : row_inc[RW-1:0];
      end else begin
        col_d = col_inc[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      left_q     <= 1'b0;
      s1_valid_q <= 1'b0;
    end else if (restart) begin
      col_q      <= '0;
      row_q      <= '0;
      left_q     <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= take && has_result;
      if (take) left_q <= rd_q.center;
    end
  end

  // line buffer; a same-address write is forwarded to the read register
  always_ff @(posedge clk_i) begin
    if (take && !flush_phase) line_mem[col_q] <= wr_data;
    if (take) begin
      if (!flush_phase && (rd_addr == col_q)) rd_q <= wr_data;
      else rd_q <= line_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_above_q     <= rd_q.above;
      s1_cen_q       <= rd_q.center;
      s1_left_q      <= left_q;
      s1_px_q        <= in_item_i.pixel_in;
      s1_above_use_q <= (row_q > RW'(1));
      s1_left_use_q  <= (col_q != '0);
      s1_right_use_q <= !last_col;
      s1_px_use_q    <= !flush_phase;
      s1_last_q      <= flush_phase && last_col;
      s1_op_q        <= op_q;
    end
  end

  // right neighbor arrives from the read issued at accept
  assign push_o = s1_valid_q;
  assign push_entry_o = '{
    terms: {s1_above_q, s1_left_q, s1_cen_q, rd_q.center, s1_px_q},
    uses:  {s1_above_use_q, s1_left_use_q, 1'b1, s1_right_use_q, s1_px_use_q},
    op:    s1_op_q,
    last:  s1_last_q
  };

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(col_q) < width_q) else $error("column counter beyond width");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= height_q) else $error("row counter beyond height");

endmodule

[hw/rtl/bcm_queue.sv]
module bcm_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bcm_pkg::bcm_entry_t push_entry_i,
  input  logic                pop_i,
  output bcm_pkg::bcm_entry_t head_o,
  output bcm_pkg::bcm_qstat_t qstat_o
);

  bcm_pkg::bcm_entry_t               slots_q [bcm_pkg::QDepth];
  logic [bcm_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [bcm_pkg::QCntW-1:0] count_q;
  logic                      do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + bcm_pkg::QPtrW'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + bcm_pkg::QPtrW'(1);
      count_q <= count_q + bcm_pkg::QCntW'(push_i) - bcm_pkg::QCntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_ptr_q] <= push_entry_i;
  end

  assign head_o        = slots_q[rd_ptr_q];
  assign qstat_o.count = count_q;
  assign qstat_o.valid = (count_q != '0);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < bcm_pkg::QCntW'(bcm_pkg::QDepth)) || do_pop)
    else $error("push into full queue");

endmodule

[hw/rtl/bcm_back.sv]
module bcm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bcm_pkg::bcm_qstat_t qstat_i,
  input  bcm_pkg::bcm_entry_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bcm_pkg::bcm_out_t   out_item_o
);

  logic              out_valid_q;
  bcm_pkg::bcm_out_t out_item_q;
  logic              all_black, any_black, result;

  // unused terms are forced neutral for the chosen operation
  assign all_black = &(head_i.terms | ~head_i.uses);
  assign any_black = |(head_i.terms & head_i.uses);

  always_comb begin
    unique case (head_i.op)
      bcm_pkg::OpErode:  result = all_black;
      bcm_pkg::OpDilate: result = any_black;
      default:           result = all_black;
    endcase
  end

  assign pop_o = qstat_i.valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) out_item_q <= '{pixel_out: result, frame_last: head_i.last};
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[hw/rtl/binary_cross_morphology_core.sv]
// Channel  Direction  Handshake              Payload
// cfg      in         cfg_we_i               cfg_idx_i, cfg_data_i
// in       in         in_valid_i/in_ready_o  in_item_i (pixel_in, flush)
// out      out        out_valid_o/out_ready_i out_item_o (pixel_out, frame_last)
//
// One item per clock while ready; a result passes stage 1, queue and out_item_q.
// One 2-bit-wide line buffer: one read per item, one write per item outside flush.
// Reset clears counters, queue and output valid; the line buffer is never cleared.
// Output stall: in_ready_o drops once the 4-entry queue plus stage 1 hold 4 items.
// A write to width, height or operation restarts the frame.
module binary_cross_morphology_core #(
  parameter int MAX_WIDTH  = bcm_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = bcm_pkg::DefMaxHeight
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bcm_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [bcm_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  bcm_pkg::bcm_in_t                in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output bcm_pkg::bcm_out_t               out_item_o
);

  bcm_pkg::bcm_qstat_t qstat;
  bcm_pkg::bcm_entry_t push_entry, head;
  logic                push, pop;

  bcm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .qstat_i      (qstat),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  bcm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .qstat_o      (qstat)
  );

  bcm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
